// ===== design/dfd_pkg.sv =====
// Shared types, codes and frame layout constants for the delimited frame deframer.
package dfd_pkg;

   localparam int BYTE_WIDTH      = 8;
   localparam int WORD_WIDTH      = 16;
   localparam int HEADER_WIDTH    = 40;
   localparam int COUNT_WIDTH     = 9;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYNC_WORD = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_END_WORD  = 2'd1;

   localparam logic [WORD_WIDTH-1:0] SYNC_WORD_RESET = 16'h0DEF;
   localparam logic [WORD_WIDTH-1:0] END_WORD_RESET  = 16'hFED0;

   // Byte positions inside a frame; the sync pair holds positions 0 and 1.
   localparam logic [COUNT_WIDTH-1:0] POS_AFTER_SYNC = 9'd2;
   localparam logic [COUNT_WIDTH-1:0] POS_LENGTH     = 9'd2;
   localparam logic [COUNT_WIDTH-1:0] POS_HDR_FIRST  = 9'd3;
   localparam logic [COUNT_WIDTH-1:0] POS_HDR_LAST   = 9'd7;
   localparam logic [COUNT_WIDTH-1:0] POS_KP_FIRST   = 9'd8;
   localparam logic [COUNT_WIDTH-1:0] POS_KP_LAST    = 9'd9;
   localparam logic [COUNT_WIDTH-1:0] POS_KD         = 9'd10;
   localparam logic [COUNT_WIDTH-1:0] POS_TAG        = 9'd11;
   localparam logic [COUNT_WIDTH-1:0] MIN_FRAME      = 9'd12;
   localparam logic [COUNT_WIDTH-1:0] OVERRUN_SLACK  = 9'd5;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_START_ERR = 2'd1,
      STATUS_OVERRUN   = 2'd2,
      STATUS_SHORT     = 2'd3
   } status_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] sync_word;
      logic [WORD_WIDTH-1:0] end_word;
   } cfg_type;

   typedef struct packed {
      status_type                    status;
      logic [BYTE_WIDTH-1:0]         frame_length;
      logic [HEADER_WIDTH-1:0]       header_info;
      logic [WORD_WIDTH-1:0]         kp_value;
      logic signed [BYTE_WIDTH-1:0]  kd_value;
      logic [BYTE_WIDTH-1:0]         tag_byte;
   } result_type;

endpackage

// ===== design/delimited_frame_deframer_top.sv =====
// Top level of the delimited frame deframer: CSRs, deframing core and result register.
//
//   channel   direction   handshake               payload
//   req       in          req_valid / req_ready   req_rx_byte
//   rsp       out         rsp_valid / rsp_ready   status, length, header, kp, kd, tag
//   csr       in          csr_valid / csr_ready   csr_index, csr_data
//
// One byte per cycle: each byte passes the core's combinational compare and count
// logic, and its result, if any, lands in the result register on the edge that takes the byte.
// A stalled result holds req_ready low until rsp_ready frees the register.
// Synchronous reset restores the CSR defaults and returns the core to hunting.
// CSR writes are always taken; indexes beyond the end word are ignored.
module delimited_frame_deframer_top
   import dfd_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [BYTE_WIDTH-1:0]       req_rx_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic [BYTE_WIDTH-1:0]       rsp_frame_length,
   output logic [HEADER_WIDTH-1:0]     rsp_header_info,
   output logic [WORD_WIDTH-1:0]       rsp_kp_value,
   output logic signed [BYTE_WIDTH-1:0] rsp_kd_value,
   output logic [BYTE_WIDTH-1:0]       rsp_tag_byte,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [WORD_WIDTH-1:0]       csr_data
);

   cfg_type    cfg_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;
   logic       req_fire;
   logic       core_hit;
   result_type core_result;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_word <= SYNC_WORD_RESET;
         cfg_ff.end_word  <= END_WORD_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SYNC_WORD: cfg_ff.sync_word <= csr_data;
            CSR_END_WORD:  cfg_ff.end_word  <= csr_data;
            default: ;
         endcase
      end
   end

   dfd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (req_fire),
      .rx_byte (req_rx_byte),
      .cfg     (cfg_ff),
      .hit     (core_hit),
      .result  (core_result)
   );

   // advance the result register whenever it is free or being drained
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= req_fire && core_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && core_hit) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_frame_length = rsp_ff.frame_length;
   assign rsp_header_info  = rsp_ff.header_info;
   assign rsp_kp_value     = rsp_ff.kp_value;
   assign rsp_kd_value     = rsp_ff.kd_value;
   assign rsp_tag_byte     = rsp_ff.tag_byte;

endmodule

// ===== design/dfd_core.sv =====
// Per-byte deframing state and the single-pass next-state and result logic.
module dfd_core
   import dfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [BYTE_WIDTH-1:0] rx_byte,
   input  cfg_type               cfg,
   output logic                  hit,
   output result_type            result
);

   logic                    in_frame_ff, in_frame_in;
   logic                    pair_pending_ff, pair_pending_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic [BYTE_WIDTH-1:0]   prev_ff, prev_in;
   logic [BYTE_WIDTH-1:0]   length_ff, length_in;
   logic [HEADER_WIDTH-1:0] header_ff, header_in;
   logic [WORD_WIDTH-1:0]   kp_ff, kp_in;
   logic [BYTE_WIDTH-1:0]   kd_ff, kd_in;
   logic [BYTE_WIDTH-1:0]   tag_ff, tag_in;
   logic [WORD_WIDTH-1:0]   pair;

   assign pair = {prev_ff, rx_byte};

   always_comb begin
      in_frame_in     = in_frame_ff;
      pair_pending_in = pair_pending_ff;
      count_in        = count_ff;
      prev_in         = rx_byte;
      length_in       = length_ff;
      header_in       = header_ff;
      kp_in           = kp_ff;
      kd_in           = kd_ff;
      tag_in          = tag_ff;
      hit             = 1'b0;
      result          = '0;

      if (!in_frame_ff) begin
         if (!pair_pending_ff) begin
            pair_pending_in = 1'b1;
         end else begin
            pair_pending_in = 1'b0;
            if (pair == cfg.sync_word) begin
               // open a frame and clear the stores
               in_frame_in = 1'b1;
               count_in    = POS_AFTER_SYNC;
               length_in   = '0;
               header_in   = '0;
               kp_in       = '0;
               kd_in       = '0;
               tag_in      = '0;
            end else begin
               hit           = 1'b1;
               result.status = STATUS_START_ERR;
            end
         end
      end else begin
         count_in = count_ff + 1'b1;
         if (count_ff == POS_LENGTH) begin
            length_in = rx_byte;
         end else if (count_ff inside {[POS_HDR_FIRST:POS_HDR_LAST]}) begin
            header_in = {header_ff[HEADER_WIDTH-BYTE_WIDTH-1:0], rx_byte};
         end else if (count_ff inside {[POS_KP_FIRST:POS_KP_LAST]}) begin
            kp_in = {kp_ff[WORD_WIDTH-BYTE_WIDTH-1:0], rx_byte};
         end else if (count_ff == POS_KD) begin
            kd_in = rx_byte;
         end else if (count_ff == POS_TAG) begin
            tag_in = rx_byte;
         end

         if (pair == cfg.end_word) begin
            hit                 = 1'b1;
            result.frame_length = length_in;
            if (count_in >= MIN_FRAME) begin
               result.status      = STATUS_OK;
               result.header_info = header_in;
               result.kp_value    = kp_in;
               result.kd_value    = kd_in;
               result.tag_byte    = tag_in;
            end else begin
               result.status = STATUS_SHORT;
            end
         end else if (count_in >= OVERRUN_SLACK &&
                      (count_in - OVERRUN_SLACK) > {1'b0, length_in}) begin
            hit                 = 1'b1;
            result.status       = STATUS_OVERRUN;
            result.frame_length = length_in;
         end

         // drop back to hunting after any result
         if (hit) begin
            in_frame_in     = 1'b0;
            pair_pending_in = 1'b0;
            count_in        = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff     <= 1'b0;
         pair_pending_ff <= 1'b0;
         count_ff        <= '0;
         prev_ff         <= '0;
         length_ff       <= '0;
         header_ff       <= '0;
         kp_ff           <= '0;
         kd_ff           <= '0;
         tag_ff          <= '0;
      end else if (step) begin
         in_frame_ff     <= in_frame_in;
         pair_pending_ff <= pair_pending_in;
         count_ff        <= count_in;
         prev_ff         <= prev_in;
         length_ff       <= length_in;
         header_ff       <= header_in;
         kp_ff           <= kp_in;
         kd_ff           <= kd_in;
         tag_ff          <= tag_in;
      end
   end

endmodule

// ===== design/dfd_checker.sv =====
// Port-level checker for the delimited frame deframer and its bind to the top level.
module dfd_checker
   import dfd_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [1:0]                   rsp_status,
   input logic [BYTE_WIDTH-1:0]        rsp_frame_length,
   input logic [HEADER_WIDTH-1:0]      rsp_header_info,
   input logic [WORD_WIDTH-1:0]        rsp_kp_value,
   input logic signed [BYTE_WIDTH-1:0] rsp_kd_value,
   input logic [BYTE_WIDTH-1:0]        rsp_tag_byte
);

   // a stalled result transaction holds valid and its status
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("stalled result dropped or changed");

   // a full, stalled result register blocks new input
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input accepted while result register is stalled");

   a_start_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_START_ERR |->
         rsp_frame_length == '0 && rsp_header_info == '0 && rsp_kp_value == '0 &&
         rsp_kd_value == '0 && rsp_tag_byte == '0)
      else $error("start mismatch result carries frame fields");

   a_abort_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_OVERRUN || rsp_status == STATUS_SHORT) |->
         rsp_header_info == '0 && rsp_kp_value == '0 && rsp_kd_value == '0 &&
         rsp_tag_byte == '0)
      else $error("aborted frame result carries payload fields");

   // with no input transaction there is nothing new to show
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !(req_valid && req_ready) |=> !rsp_valid)
      else $error("result appeared without an input transaction");

endmodule

bind delimited_frame_deframer_top dfd_checker u_dfd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_frame_length (rsp_frame_length),
   .rsp_header_info  (rsp_header_info),
   .rsp_kp_value     (rsp_kp_value),
   .rsp_kd_value     (rsp_kd_value),
   .rsp_tag_byte     (rsp_tag_byte)
);

// ===== test/tb_delimited_frame_deframer_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the delimited frame deframer against a tracked frame state.
module tb_delimited_frame_deframer_top;
   import dfd_pkg::*;

   localparam int LIMIT_CYCLES  = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_BYTES   = 36;

   // Register indexes past the end word; writes to them change nothing
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_HI = 2'd3;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [BYTE_WIDTH-1:0]        req_rx_byte = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [1:0]                   rsp_status;
   logic [BYTE_WIDTH-1:0]        rsp_frame_length;
   logic [HEADER_WIDTH-1:0]      rsp_header_info;
   logic [WORD_WIDTH-1:0]        rsp_kp_value;
   logic signed [BYTE_WIDTH-1:0] rsp_kd_value;
   logic [BYTE_WIDTH-1:0]        rsp_tag_byte;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]   csr_index = CSR_SYNC_WORD;
   logic [WORD_WIDTH-1:0]        csr_data = '0;

   // Tracked copy of the deframer's registers and state
   logic [WORD_WIDTH-1:0]   cur_sync = SYNC_WORD_RESET;
   logic [WORD_WIDTH-1:0]   cur_end = END_WORD_RESET;
   logic                    hunt_done = 1'b0;
   logic                    half_pair = 1'b0;
   logic [COUNT_WIDTH-1:0]  frame_pos = '0;
   logic [BYTE_WIDTH-1:0]   last_byte = '0;
   logic [BYTE_WIDTH-1:0]   len_field = '0;
   logic [HEADER_WIDTH-1:0] hdr_field = '0;
   logic [WORD_WIDTH-1:0]   kp_field = '0;
   logic [BYTE_WIDTH-1:0]   kd_field = '0;
   logic [BYTE_WIDTH-1:0]   tag_field = '0;

   result_type            expected_reports[$];
   logic [BYTE_WIDTH-1:0] rx_bytes_q[$];
   int                    bytes_queued = 0;
   int                    send_idle_pct = 0;
   int                    recv_idle_pct = 0;
   int                    fail_count = 0;
   int                    cycle_count = 0;

   delimited_frame_deframer_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_frame_length (rsp_frame_length),
      .rsp_header_info  (rsp_header_info),
      .rsp_kp_value     (rsp_kp_value),
      .rsp_kd_value     (rsp_kd_value),
      .rsp_tag_byte     (rsp_tag_byte),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   function automatic result_type make_report(input status_type st,
         input logic [BYTE_WIDTH-1:0] len, input logic [HEADER_WIDTH-1:0] hdr,
         input logic [WORD_WIDTH-1:0] kp, input logic [BYTE_WIDTH-1:0] kd,
         input logic [BYTE_WIDTH-1:0] tag);
      result_type r;
      r.status       = st;
      r.frame_length = len;
      r.header_info  = hdr;
      r.kp_value     = kp;
      r.kd_value     = kd;
      r.tag_byte     = tag;
      return r;
   endfunction

   task automatic enqueue_report(input result_type r);
      expected_reports = {expected_reports, r};
   endtask

   // Advance the tracked deframer by one accepted byte and queue any report it causes.
   task automatic track_rx_byte(input logic [BYTE_WIDTH-1:0] b);
      logic [COUNT_WIDTH-1:0] pos;
      logic [WORD_WIDTH-1:0]  pair;
      pair = {last_byte, b};
      last_byte = b;
      if (!hunt_done) begin
         if (!half_pair) begin
            half_pair = 1'b1;
         end else begin
            half_pair = 1'b0;
            if (pair == cur_sync) begin
               hunt_done = 1'b1;
               frame_pos = POS_AFTER_SYNC;
               len_field = '0;
               hdr_field = '0;
               kp_field  = '0;
               kd_field  = '0;
               tag_field = '0;
            end else begin
               enqueue_report(make_report(STATUS_START_ERR, '0, '0, '0, '0, '0));
            end
         end
      end else begin
         pos = frame_pos;
         frame_pos = frame_pos + 1'b1;
         if (pos == POS_LENGTH) len_field = b;
         else if (pos >= POS_HDR_FIRST && pos <= POS_HDR_LAST)
            hdr_field = {hdr_field[HEADER_WIDTH-BYTE_WIDTH-1:0], b};
         else if (pos >= POS_KP_FIRST && pos <= POS_KP_LAST)
            kp_field = {kp_field[BYTE_WIDTH-1:0], b};
         else if (pos == POS_KD) kd_field = b;
         else if (pos == POS_TAG) tag_field = b;

         if (pair == cur_end) begin
            if (frame_pos >= MIN_FRAME)
               enqueue_report(make_report(STATUS_OK, len_field, hdr_field,
                                          kp_field, kd_field, tag_field));
            else
               enqueue_report(make_report(STATUS_SHORT, len_field,
                                          '0, '0, '0, '0));
            hunt_done = 1'b0;
            half_pair = 1'b0;
            frame_pos = '0;
         end else if (frame_pos >= OVERRUN_SLACK &&
                      (frame_pos - OVERRUN_SLACK) > {1'b0, len_field}) begin
            enqueue_report(make_report(STATUS_OVERRUN, len_field,
                                       '0, '0, '0, '0));
            hunt_done = 1'b0;
            half_pair = 1'b0;
            frame_pos = '0;
         end
      end
   endtask

   task automatic push_byte(input logic [BYTE_WIDTH-1:0] b);
      rx_bytes_q = {rx_bytes_q, b};
      bytes_queued++;
   endtask

   task automatic queue_frame(input int length, input int payload, input bit with_stop);
      push_byte(cur_sync[15:8]);
      push_byte(cur_sync[7:0]);
      push_byte(length[7:0]);
      repeat (payload) push_byte(8'($urandom_range(255)));
      if (with_stop) begin
         push_byte(cur_end[15:8]);
         push_byte(cur_end[7:0]);
      end
   endtask

   // Mostly well-formed frames with random content; the rest short, overrun, noise, broken.
   task automatic queue_random_traffic();
      int kind;
      int payload;
      int length;
      kind = $urandom_range(99);
      if (kind < 60) begin
         payload = $urandom_range(7, 16);
         length  = payload - 1 + $urandom_range(0, 12);
         queue_frame(length, payload, 1'b1);
      end else if (kind < 72) begin
         queue_frame($urandom_range(6, 255), $urandom_range(0, 6), 1'b1);
      end else if (kind < 84) begin
         length = $urandom_range(0, 12);
         queue_frame(length, length + 3, 1'b0);
      end else if (kind < 94) begin
         // keep pairing aligned most of the time
         repeat ((kind < 92) ? 2 * $urandom_range(1, 3) : 1)
            push_byte(8'($urandom_range(255)));
      end else begin
         push_byte(cur_sync[15:8]);
         push_byte(cur_sync[7:0] ^ (8'd1 << $urandom_range(7)));
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [WORD_WIDTH-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == CSR_SYNC_WORD) cur_sync = data;
      else if (index == CSR_END_WORD) cur_end = data;
   endtask

   // Hold off until every queued byte is taken and every report has come back.
   task automatic wait_drained();
      while (rx_bytes_q.size() != 0 || req_valid || expected_reports.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) track_rx_byte(req_rx_byte);
         if (!req_valid || req_ready) begin
            if (rx_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid   <= 1'b1;
               req_rx_byte <= rx_bytes_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : report_monitor
      result_type got;
      result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = make_report(status_type'(rsp_status), rsp_frame_length, rsp_header_info,
                              rsp_kp_value, rsp_kd_value, rsp_tag_byte);
            if (expected_reports.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected report: status %0d len %h hdr %h kp %h kd %h tag %h",
                           got.status, got.frame_length, got.header_info, got.kp_value,
                           got.kd_value, got.tag_byte);
            end else begin
               want = expected_reports.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("report mismatch: exp st %0d len %h hdr %h kp %h kd %h tag %h",
                              want.status, want.frame_length, want.header_info,
                              want.kp_value, want.kd_value, want.tag_byte);
                     $display("                 got st %0d len %h hdr %h kp %h kd %h tag %h",
                              got.status, got.frame_length, got.header_info,
                              got.kp_value, got.kd_value, got.tag_byte);
                  end
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("delimited_frame_deframer_top regression: fail");
      $finish;
   end

   initial begin
      logic [WORD_WIDTH-1:0] next_sync;
      logic [WORD_WIDTH-1:0] next_end;
      int                    start_count;
      int                    mode;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset words: full frame with extreme fields, start mismatch, short frame, overrun
      push_byte(8'h0D); push_byte(8'hEF); push_byte(8'hFF);
      push_byte(8'h80); push_byte(8'h01); push_byte(8'hFF); push_byte(8'h00); push_byte(8'h7F);
      push_byte(8'hFF); push_byte(8'h00); push_byte(8'h80); push_byte(8'hFF);
      push_byte(8'hFE); push_byte(8'hD0);
      push_byte(8'h00); push_byte(8'h00);
      push_byte(8'h0D); push_byte(8'hEF); push_byte(8'h05); push_byte(8'hFE); push_byte(8'hD0);
      push_byte(8'h0D); push_byte(8'hEF); push_byte(8'h00);
      push_byte(8'h11); push_byte(8'h22); push_byte(8'h33);
      wait_drained();

      // Unused indexes must leave both words alone
      write_csr(CSR_SPARE_LO, 16'($urandom_range(16'hFFFF)));
      write_csr(CSR_SPARE_HI, 16'($urandom_range(16'hFFFF)));
      write_csr(CSR_SYNC_WORD, 16'h12AB);
      write_csr(CSR_END_WORD, 16'hAB34);
      @(negedge clock);
      // Second sync byte doubles as the first stop byte
      push_byte(8'h12); push_byte(8'hAB); push_byte(8'h34);

      for (int phase = 1; phase <= 6; phase++) begin
         wait_drained();
         next_sync = 16'($urandom_range(16'hFFFF));
         next_end  = 16'($urandom_range(16'hFFFF));
         case (phase)
            1: begin
               next_sync = SYNC_WORD_RESET;
               next_end  = END_WORD_RESET;
            end
            2: begin
               next_sync = 16'h0000;
               next_end  = 16'hFFFF;
            end
            3: begin
               next_sync = 16'hFFFF;
               next_end  = 16'h0000;
            end
            5: next_end = {next_sync[7:0], next_end[7:0]};
            default: ;
         endcase
         write_csr(CSR_SYNC_WORD, next_sync);
         write_csr(CSR_END_WORD, next_end);
         @(negedge clock);
         mode = (phase - 1) % 4;
         send_idle_pct = (mode == 1) ? 45 : (mode == 3) ? 34 : 0;
         recv_idle_pct = (mode == 2) ? 45 : (mode == 3) ? 34 : 0;
         // Longest legal frame: the length field reaches its ceiling
         if (phase == 1) queue_frame(255, 256, 1'b1);
         start_count = bytes_queued;
         while (bytes_queued - start_count < PHASE_BYTES) queue_random_traffic();
      end
      wait_drained();

      if (fail_count == 0 && expected_reports.size() == 0)
         $display("delimited_frame_deframer_top regression: pass");
      else
         $display("delimited_frame_deframer_top regression: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/dfd_pkg.sv
design/dfd_core.sv
design/delimited_frame_deframer_top.sv
design/dfd_checker.sv
test/tb_delimited_frame_deframer_top.sv
